// File: hdl/two_stack_machine_alu_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef TWO_STACK_MACHINE_ALU_UNIT_DEFINES_SVH
`define TWO_STACK_MACHINE_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied.
`define TSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked during reset as well.
`define TSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tsm_pkg.sv
`default_nettype none
package tsm_pkg;

  localparam int DATA_DEPTH_DEF   = 64;
  localparam int RETURN_DEPTH_DEF = 64;
  localparam int CELL_WIDTH_DEF   = 64;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  localparam logic [4:0] OP_LIT   = 5'd0;
  localparam logic [4:0] OP_DROP  = 5'd1;
  localparam logic [4:0] OP_DUP   = 5'd2;
  localparam logic [4:0] OP_SWAP  = 5'd3;
  localparam logic [4:0] OP_OVER  = 5'd4;
  localparam logic [4:0] OP_ROT   = 5'd5;
  localparam logic [4:0] OP_ADD   = 5'd6;
  localparam logic [4:0] OP_SUB   = 5'd7;
  localparam logic [4:0] OP_MUL   = 5'd8;
  localparam logic [4:0] OP_DIV   = 5'd9;
  localparam logic [4:0] OP_EQ    = 5'd10;
  localparam logic [4:0] OP_NOT   = 5'd11;
  localparam logic [4:0] OP_AND   = 5'd12;
  localparam logic [4:0] OP_OR    = 5'd13;
  localparam logic [4:0] OP_LT    = 5'd14;
  localparam logic [4:0] OP_GT    = 5'd15;
  localparam logic [4:0] OP_CELLS = 5'd16;
  localparam logic [4:0] OP_TOR   = 5'd17;
  localparam logic [4:0] OP_FROMR = 5'd18;
  localparam logic [4:0] OP_COPYR = 5'd19;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDER   = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  typedef struct packed {
    logic [4:0]         mode;
    logic signed [63:0] literal;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] top_value;
    logic [1:0]         status;
    logic [6:0]         data_depth;
    logic [6:0]         return_depth;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  mode;
    logic [63:0] literal;
    logic [1:0]  need;
    logic        need_r;
    logic        grow_d;
    logic        grow_r;
  } dec_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [63:0] a;
    logic [63:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } md_rsp_t;

endpackage
`default_nettype wire

// File: hdl/two_stack_machine_alu_unit.sv
`default_nettype none
// Stack machine core: one instruction per item on a data stack and a return
// stack held in single-port-read memories. An item is taken when start is
// high and busy is low; busy rises only while the two-entry instruction queue
// is full. Each item gives one result, shown for a single cycle with
// out_strobe, which the receiver must take then. A stack instruction runs
// idle, rd0 to rd3 (three reads through the data stack's one read port),
// exec, then the serial memory write-backs (0 to 3, three for rot) and out.
// mul and div wait in the md state: three 32x32 partial products for mul,
// the one-bit-per-cycle divider for div. Failed steps go from exec to out.
module two_stack_machine_alu_unit #(
  parameter int DATA_DEPTH   = tsm_pkg::DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = tsm_pkg::RETURN_DEPTH_DEF,
  parameter int CELL_WIDTH   = tsm_pkg::CELL_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire tsm_pkg::in_item_t in_item,
  output logic                   out_strobe,
  output tsm_pkg::out_item_t     out_item
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  tsm_pkg::dec_t    push_dec;
  tsm_pkg::dec_t    pop_dec;
  tsm_pkg::md_req_t md_req;
  tsm_pkg::md_rsp_t md_rsp;

  tsm_front u_front (
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .dec     (push_dec)
  );

  tsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_dec (push_dec),
    .pop      (pop),
    .pop_dec  (pop_dec),
    .full     (q_full),
    .empty    (q_empty)
  );

  tsm_back #(
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH),
    .CELL_WIDTH   (CELL_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_dec      (pop_dec),
    .q_pop      (pop),
    .md_req     (md_req),
    .md_rsp     (md_rsp),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  tsm_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

endmodule
`default_nettype wire

// File: hdl/tsm_front.sv
`default_nettype none
module tsm_front (
  input  wire logic              start,
  input  wire tsm_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   busy,
  output logic                   push,
  output tsm_pkg::dec_t          dec
);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    dec         = '0;
    dec.mode    = in_item.mode;
    dec.literal = in_item.literal;
    unique case (in_item.mode) inside
      tsm_pkg::OP_LIT: begin
        dec.grow_d = 1'b1;
      end
      tsm_pkg::OP_DROP, tsm_pkg::OP_NOT, tsm_pkg::OP_CELLS: begin
        dec.need = 2'd1;
      end
      tsm_pkg::OP_DUP: begin
        dec.need   = 2'd1;
        dec.grow_d = 1'b1;
      end
      tsm_pkg::OP_OVER: begin
        dec.need   = 2'd2;
        dec.grow_d = 1'b1;
      end
      tsm_pkg::OP_ROT: begin
        dec.need = 2'd3;
      end
      tsm_pkg::OP_TOR: begin
        dec.need   = 2'd1;
        dec.grow_r = 1'b1;
      end
      tsm_pkg::OP_FROMR, tsm_pkg::OP_COPYR: begin
        dec.need_r = 1'b1;
        dec.grow_d = 1'b1;
      end
      tsm_pkg::OP_SWAP, tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL,
      tsm_pkg::OP_DIV, tsm_pkg::OP_EQ, tsm_pkg::OP_AND, tsm_pkg::OP_OR,
      tsm_pkg::OP_LT, tsm_pkg::OP_GT: begin
        dec.need = 2'd2;
      end
      default: begin
        dec.need = 2'd0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/tsm_queue.sv
`default_nettype none
module tsm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tsm_pkg::dec_t push_dec,
  input  wire logic          pop,
  output tsm_pkg::dec_t      pop_dec,
  output logic               full,
  output logic               empty
);

  tsm_pkg::dec_t                ent_r [tsm_pkg::QDEPTH];
  logic [tsm_pkg::QAW-1:0]      wp_r;
  logic [tsm_pkg::QAW-1:0]      rp_r;
  logic [tsm_pkg::QAW:0]        cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (cnt_r == (tsm_pkg::QAW+1)'(tsm_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_dec = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/tsm_muldiv.sv
`default_nettype none
module tsm_muldiv (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tsm_pkg::md_req_t req,
  output tsm_pkg::md_rsp_t      rsp
);

  localparam int DIV_STEPS = 64;
  localparam int SW        = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_MUL  = 3'b010,
    M_DIV  = 3'b100
  } md_state_t;

  md_state_t     state_r;
  logic [63:0]   a_r;
  logic [63:0]   b_r;
  logic [63:0]   acc_r;
  logic [63:0]   rem_r;
  logic [SW-1:0] step_r;
  logic          neg_r;
  logic          done_r;
  logic [63:0]   res_r;
  logic [31:0]   ma;
  logic [31:0]   mb;
  logic [63:0]   mp;
  logic [64:0]   shifted;
  logic [64:0]   diff;
  logic [63:0]   qfin;

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  // One 32x32 multiplier, operands chosen by the step.
  always_comb begin
    unique case (step_r[1:0])
      2'd0:    begin ma = a_r[31:0];  mb = b_r[31:0];  end
      2'd1:    begin ma = a_r[31:0];  mb = b_r[63:32]; end
      default: begin ma = a_r[63:32]; mb = b_r[31:0];  end
    endcase
    mp = 64'(ma) * 64'(mb);
  end

  assign shifted = {rem_r, a_r[63]};
  assign diff    = shifted - {1'b0, b_r};
  assign qfin    = {a_r[62:0], !diff[64]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          step_r <= '0;
          if (req.start) begin
            if (req.is_div) begin
              // Work on magnitudes, fix the sign at the end.
              a_r     <= req.a[63] ? 64'd0 - req.a : req.a;
              b_r     <= req.b[63] ? 64'd0 - req.b : req.b;
              neg_r   <= req.a[63] ^ req.b[63];
              rem_r   <= '0;
              state_r <= M_DIV;
            end else begin
              a_r     <= req.a;
              b_r     <= req.b;
              acc_r   <= '0;
              state_r <= M_MUL;
            end
          end
        end
        M_MUL: begin
          if (step_r == SW'(0)) begin
            acc_r <= mp;
          end else begin
            acc_r <= acc_r + {mp[31:0], 32'd0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == SW'(2)) begin
            res_r   <= acc_r + {mp[31:0], 32'd0};
            done_r  <= 1'b1;
            state_r <= M_IDLE;
          end
        end
        M_DIV: begin
          rem_r  <= diff[64] ? shifted[63:0] : diff[63:0];
          a_r    <= qfin;
          step_r <= step_r + 1'b1;
          if (step_r == SW'(DIV_STEPS - 1)) begin
            res_r   <= neg_r ? 64'd0 - qfin : qfin;
            done_r  <= 1'b1;
            state_r <= M_IDLE;
          end
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/tsm_back.sv
`default_nettype none
module tsm_back #(
  parameter int DATA_DEPTH   = tsm_pkg::DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = tsm_pkg::RETURN_DEPTH_DEF,
  parameter int CELL_WIDTH   = tsm_pkg::CELL_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire tsm_pkg::dec_t    q_dec,
  output logic                  q_pop,
  output tsm_pkg::md_req_t      md_req,
  input  wire tsm_pkg::md_rsp_t md_rsp,
  output logic                  out_strobe,
  output tsm_pkg::out_item_t    out_item
);

  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int RAW = $clog2(RETURN_DEPTH);
  localparam int DCW = $clog2(DATA_DEPTH + 1);
  localparam int RCW = $clog2(RETURN_DEPTH + 1);
  localparam int CW  = CELL_WIDTH;

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_RD0  = 9'b000000010,
    B_RD1  = 9'b000000100,
    B_RD2  = 9'b000001000,
    B_RD3  = 9'b000010000,
    B_EXEC = 9'b000100000,
    B_MD   = 9'b001000000,
    B_WR   = 9'b010000000,
    B_OUT  = 9'b100000000
  } back_state_t;

  back_state_t   state_r;
  tsm_pkg::dec_t cur_r;
  logic [DCW-1:0] dcnt_r;
  logic [RCW-1:0] rcnt_r;
  logic [CW-1:0]  t_r;
  logic [CW-1:0]  s_r;
  logic [CW-1:0]  u_r;
  logic [CW-1:0]  rt_r;
  logic [CW-1:0]  dq_r;
  logic [CW-1:0]  rq_r;
  logic [1:0]     status_r;
  logic [CW-1:0]  top_r;
  logic [1:0]     wn_r;
  logic [DAW-1:0] wa_r [3];
  logic [CW-1:0]  wd_r [3];
  logic           rwe_r;
  logic [RAW-1:0] rwa_r;
  logic [CW-1:0]  rwd_r;

  logic [CW-1:0] dmem [DATA_DEPTH];
  logic [CW-1:0] rmem [RETURN_DEPTH];

  logic [DCW-1:0] dm1_f;
  logic [DCW-1:0] dm2_f;
  logic [DCW-1:0] dm3_f;
  logic [RCW-1:0] rm1_f;
  logic [DAW-1:0] dm1;
  logic [DAW-1:0] dm2;
  logic [DAW-1:0] dm3;
  logic [DAW-1:0] dp0;
  logic [RAW-1:0] rm1;
  logic [RAW-1:0] rp0;
  logic [DAW-1:0] d_raddr;
  logic           under;
  logic           over;
  logic           divz;
  logic [1:0]     st;
  logic           is_md;
  logic [CW-1:0]  cur_top;
  logic [CW-1:0]  below;
  logic [CW-1:0]  alu_v;
  logic [CW-1:0]  lit_c;

  assign dm1_f = dcnt_r - DCW'(1);
  assign dm2_f = dcnt_r - DCW'(2);
  assign dm3_f = dcnt_r - DCW'(3);
  assign rm1_f = rcnt_r - RCW'(1);
  assign dm1   = dm1_f[DAW-1:0];
  assign dm2   = dm2_f[DAW-1:0];
  assign dm3   = dm3_f[DAW-1:0];
  assign dp0   = dcnt_r[DAW-1:0];
  assign rm1   = rm1_f[RAW-1:0];
  assign rp0   = rcnt_r[RAW-1:0];
  assign lit_c = cur_r.literal[CW-1:0];

  always_comb begin
    unique case (state_r)
      B_RD0:   d_raddr = dm1;
      B_RD1:   d_raddr = dm2;
      default: d_raddr = dm3;
    endcase
  end

  // Data and return stacks: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (state_r == B_WR && wn_r != 2'd0) begin
      dmem[wa_r[0]] <= wd_r[0];
    end
    dq_r <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == B_WR && rwe_r) begin
      rmem[rwa_r] <= rwd_r;
    end
    rq_r <= rmem[rm1];
  end

  assign under = (dcnt_r < DCW'(cur_r.need)) || (cur_r.need_r && rcnt_r == '0);
  assign over  = (cur_r.grow_d && dcnt_r >= DCW'(DATA_DEPTH)) ||
                 (cur_r.grow_r && rcnt_r >= RCW'(RETURN_DEPTH));
  assign divz  = (cur_r.mode == tsm_pkg::OP_DIV) && (t_r == '0);
  assign is_md = (cur_r.mode == tsm_pkg::OP_MUL) || (cur_r.mode == tsm_pkg::OP_DIV);

  always_comb begin
    if (under) begin
      st = tsm_pkg::ST_UNDER;
    end else if (over) begin
      st = tsm_pkg::ST_OVER;
    end else if (divz) begin
      st = tsm_pkg::ST_DIVZERO;
    end else begin
      st = tsm_pkg::ST_OK;
    end
  end

  assign cur_top = (dcnt_r != '0) ? t_r : '0;
  assign below   = (dcnt_r >= DCW'(2)) ? s_r : '0;

  always_comb begin
    unique case (cur_r.mode)
      tsm_pkg::OP_ADD: alu_v = s_r + t_r;
      tsm_pkg::OP_SUB: alu_v = s_r - t_r;
      tsm_pkg::OP_EQ:  alu_v = (s_r == t_r) ? '1 : '0;
      tsm_pkg::OP_AND: alu_v = s_r & t_r;
      tsm_pkg::OP_OR:  alu_v = s_r | t_r;
      tsm_pkg::OP_LT:  alu_v = ($signed(s_r) < $signed(t_r)) ? '1 : '0;
      tsm_pkg::OP_GT:  alu_v = ($signed(t_r) < $signed(s_r)) ? '1 : '0;
      default:         alu_v = '0;
    endcase
  end

  assign q_pop         = (state_r == B_IDLE) && !q_empty;
  assign md_req.start  = (state_r == B_EXEC) && (st == tsm_pkg::ST_OK) && is_md;
  assign md_req.is_div = (cur_r.mode == tsm_pkg::OP_DIV);
  assign md_req.a      = 64'(signed'(s_r));
  assign md_req.b      = 64'(signed'(t_r));

  assign out_strobe            = (state_r == B_OUT);
  assign out_item.top_value    = 64'(signed'(top_r));
  assign out_item.status       = status_r;
  assign out_item.data_depth   = 7'(dcnt_r);
  assign out_item.return_depth = 7'(rcnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      dcnt_r  <= '0;
      rcnt_r  <= '0;
      wn_r    <= '0;
      rwe_r   <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            cur_r   <= q_dec;
            state_r <= B_RD0;
          end
        end
        B_RD0: begin
          state_r <= B_RD1;
        end
        B_RD1: begin
          t_r     <= dq_r;
          rt_r    <= rq_r;
          state_r <= B_RD2;
        end
        B_RD2: begin
          s_r     <= dq_r;
          state_r <= B_RD3;
        end
        B_RD3: begin
          u_r     <= dq_r;
          state_r <= B_EXEC;
        end
        B_EXEC: begin
          status_r <= st;
          top_r    <= cur_top;
          wn_r     <= 2'd0;
          rwe_r    <= 1'b0;
          state_r  <= B_OUT;
          if (st == tsm_pkg::ST_OK) begin
            unique case (cur_r.mode) inside
              tsm_pkg::OP_LIT: begin
                wa_r[0] <= dp0;  wd_r[0] <= lit_c;  wn_r <= 2'd1;
                top_r   <= lit_c;
                dcnt_r  <= dcnt_r + 1'b1;
                state_r <= B_WR;
              end
              tsm_pkg::OP_DROP: begin
                top_r  <= below;
                dcnt_r <= dcnt_r - 1'b1;
              end
              tsm_pkg::OP_DUP: begin
                wa_r[0] <= dp0;  wd_r[0] <= t_r;  wn_r <= 2'd1;
                dcnt_r  <= dcnt_r + 1'b1;
                state_r <= B_WR;
              end
              tsm_pkg::OP_SWAP: begin
                wa_r[0] <= dm1;  wd_r[0] <= s_r;
                wa_r[1] <= dm2;  wd_r[1] <= t_r;
                wn_r    <= 2'd2;
                top_r   <= s_r;
                state_r <= B_WR;
              end
              tsm_pkg::OP_OVER: begin
                wa_r[0] <= dp0;  wd_r[0] <= s_r;  wn_r <= 2'd1;
                top_r   <= s_r;
                dcnt_r  <= dcnt_r + 1'b1;
                state_r <= B_WR;
              end
              tsm_pkg::OP_ROT: begin
                wa_r[0] <= dm3;  wd_r[0] <= s_r;
                wa_r[1] <= dm2;  wd_r[1] <= t_r;
                wa_r[2] <= dm1;  wd_r[2] <= u_r;
                wn_r    <= 2'd3;
                top_r   <= u_r;
                state_r <= B_WR;
              end
              tsm_pkg::OP_MUL, tsm_pkg::OP_DIV: begin
                state_r <= B_MD;
              end
              tsm_pkg::OP_NOT: begin
                wa_r[0] <= dm1;  wd_r[0] <= ~t_r;  wn_r <= 2'd1;
                top_r   <= ~t_r;
                state_r <= B_WR;
              end
              tsm_pkg::OP_CELLS: begin
                wa_r[0] <= dm1;  wd_r[0] <= t_r << 3;  wn_r <= 2'd1;
                top_r   <= t_r << 3;
                state_r <= B_WR;
              end
              tsm_pkg::OP_TOR: begin
                rwe_r   <= 1'b1;  rwa_r <= rp0;  rwd_r <= t_r;
                top_r   <= below;
                dcnt_r  <= dcnt_r - 1'b1;
                rcnt_r  <= rcnt_r + 1'b1;
                state_r <= B_WR;
              end
              tsm_pkg::OP_FROMR, tsm_pkg::OP_COPYR: begin
                wa_r[0] <= dp0;  wd_r[0] <= rt_r;  wn_r <= 2'd1;
                top_r   <= rt_r;
                dcnt_r  <= dcnt_r + 1'b1;
                if (cur_r.mode == tsm_pkg::OP_FROMR) begin
                  rcnt_r <= rcnt_r - 1'b1;
                end
                state_r <= B_WR;
              end
              tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_EQ, tsm_pkg::OP_AND,
              tsm_pkg::OP_OR, tsm_pkg::OP_LT, tsm_pkg::OP_GT: begin
                wa_r[0] <= dm2;  wd_r[0] <= alu_v;  wn_r <= 2'd1;
                top_r   <= alu_v;
                dcnt_r  <= dcnt_r - 1'b1;
                state_r <= B_WR;
              end
              default: begin
                state_r <= B_OUT;
              end
            endcase
          end
        end
        B_MD: begin
          if (md_rsp.done) begin
            wa_r[0] <= dm2;
            wd_r[0] <= md_rsp.res[CW-1:0];
            wn_r    <= 2'd1;
            top_r   <= md_rsp.res[CW-1:0];
            dcnt_r  <= dcnt_r - 1'b1;
            state_r <= B_WR;
          end
        end
        B_WR: begin
          // Advance the write list one entry per cycle.
          wa_r[0] <= wa_r[1];  wd_r[0] <= wd_r[1];
          wa_r[1] <= wa_r[2];  wd_r[1] <= wd_r[2];
          rwe_r   <= 1'b0;
          if (wn_r != 2'd0) begin
            wn_r <= wn_r - 1'b1;
          end
          if (wn_r <= 2'd1) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          state_r <= B_IDLE;
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/tsm_checker.sv
`default_nettype none
`include "two_stack_machine_alu_unit_defines.svh"
module tsm_checker #(
  parameter int DATA_DEPTH = tsm_pkg::DATA_DEPTH_DEF
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_strobe,
  input wire tsm_pkg::out_item_t out_item
);

  logic small_stack;

  assign small_stack = (DATA_DEPTH < 128);

  `TSM_ASSERT_NEXT(a_rst_quiet, !rst_n, !out_strobe, "result strobe right after reset")
  `TSM_ASSERT_NEXT(a_strobe_pulse, out_strobe, !out_strobe, "result strobe held two cycles")
  `TSM_ASSERT_NOW(a_empty_top, out_strobe && small_stack && out_item.data_depth == 7'd0, out_item.top_value == 64'sd0, "nonzero top on empty stack")

endmodule

bind two_stack_machine_alu_unit tsm_checker #(
  .DATA_DEPTH (DATA_DEPTH)
) u_tsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
`default_nettype wire
